// ===== src/mu7_pkg.sv =====
`default_nettype none
package mu7_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned SHIFT_W = 4;

  localparam logic [MODE_W-1:0] MODE_ASCII = 4'd0;
  localparam logic [MODE_W-1:0] MODE_AMP = 4'd9;

  localparam logic [BYTE_W-1:0] CHR_AMP = 8'h26;
  localparam logic [BYTE_W-1:0] CHR_HYPHEN = 8'h2d;
  localparam logic [BYTE_W-1:0] CHR_PLUS = 8'h2b;
  localparam logic [BYTE_W-1:0] CHR_COMMA = 8'h2c;
  localparam logic [BYTE_W-1:0] CHR_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_9 = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_UA = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_UZ = 8'h5a;
  localparam logic [BYTE_W-1:0] CHR_LA = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_LZ = 8'h7a;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    HY_EMIT,
    HY_QUIET,
    HY_ERROR
  } hyphen_act_t;

  typedef struct packed {
    logic [MODE_W-1:0]  next;
    hyphen_act_t        on_hyphen;
    logic               split;
    logic [SHIFT_W-1:0] shift;
  } mode_row_t;

  typedef struct packed {
    logic               valid;
    logic [SEXTET_W-1:0] value;
  } sextet_t;

  // Result of the decode stage as it moves into the output register.
  typedef struct packed {
    logic              fire;
    logic              status;
    logic [UNIT_W-1:0] code_unit;
  } mu7_res_t;

  function automatic sextet_t sextet_of(input logic [BYTE_W-1:0] b);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (b == CHR_PLUS) begin
      s.value = 6'd62;
    end else if (b == CHR_COMMA) begin
      s.value = 6'd63;
    end else if (b >= CHR_0 && b <= CHR_9) begin
      s.value = SEXTET_W'(b - CHR_0 + 8'd52);
    end else if (b >= CHR_UA && b <= CHR_UZ) begin
      s.value = SEXTET_W'(b - CHR_UA);
    end else if (b >= CHR_LA && b <= CHR_LZ) begin
      s.value = SEXTET_W'(b - CHR_LA + 8'd26);
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  function automatic mode_row_t mode_row(input logic [MODE_W-1:0] m);
    mode_row_t r;
    unique case (m)
      4'd1:    r = '{next: 4'd2, on_hyphen: HY_QUIET, split: 1'b0, shift: 4'd10};
      4'd2:    r = '{next: 4'd3, on_hyphen: HY_ERROR, split: 1'b0, shift: 4'd4};
      4'd3:    r = '{next: 4'd4, on_hyphen: HY_ERROR, split: 1'b1, shift: 4'd2};
      4'd4:    r = '{next: 4'd5, on_hyphen: HY_QUIET, split: 1'b0, shift: 4'd8};
      4'd5:    r = '{next: 4'd6, on_hyphen: HY_ERROR, split: 1'b0, shift: 4'd2};
      4'd6:    r = '{next: 4'd7, on_hyphen: HY_ERROR, split: 1'b1, shift: 4'd4};
      4'd7:    r = '{next: 4'd8, on_hyphen: HY_QUIET, split: 1'b0, shift: 4'd6};
      4'd8:    r = '{next: 4'd1, on_hyphen: HY_ERROR, split: 1'b1, shift: 4'd0};
      4'd9:    r = '{next: 4'd2, on_hyphen: HY_EMIT,  split: 1'b0, shift: 4'd10};
      default: r = '{next: MODE_ASCII, on_hyphen: HY_ERROR, split: 1'b0, shift: 4'd0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/mu7_if.sv =====
`default_nettype none
interface mu7_in_if;
  import mu7_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mu7_out_if;
  import mu7_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [UNIT_W-1:0] code_unit;

  modport source (output valid, output status, output code_unit, input ready);
  modport sink (input valid, input status, input code_unit, output ready);
endinterface
`default_nettype wire

// ===== src/mu7_core.sv =====
`default_nettype none
module mu7_core
  import mu7_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mu7_in_if.sink    in_ch,
  input  wire logic out_free,
  output mu7_res_t  res
);

  logic              stage_vld_r, stage_vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [UNIT_W-1:0] acc_r, acc_nxt;
  logic [UNIT_W-1:0] carry_r, carry_nxt;

  logic              has_res;
  logic              res_status;
  logic [UNIT_W-1:0] res_unit;
  logic              move;
  logic              take;
  mode_row_t         row;
  sextet_t           sx;
  logic [SEXTET_W+UNIT_W-1:0] split_val;
  logic [SEXTET_W+UNIT_W-1:0] place_val;

  assign row = mode_row(mode_r);
  assign sx = sextet_of(byte_r);
  // Upper part is the sextet shifted right, lower part is the carry left behind.
  assign split_val = {sx.value, {UNIT_W{1'b0}}} >> row.shift;
  assign place_val = {{UNIT_W{1'b0}}, sx.value} << row.shift;

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    carry_nxt = carry_r;
    has_res = 1'b0;
    res_status = STATUS_OK;
    res_unit = '0;
    if (mode_r == MODE_ASCII || mode_r > MODE_AMP) begin
      if (byte_r == CHR_AMP) begin
        acc_nxt = '0;
        carry_nxt = '0;
        mode_nxt = MODE_AMP;
      end else begin
        mode_nxt = MODE_ASCII;
        acc_nxt = '0;
        has_res = 1'b1;
        res_unit = UNIT_W'(byte_r);
      end
    end else if (byte_r == CHR_HYPHEN) begin
      mode_nxt = MODE_ASCII;
      case (row.on_hyphen)
        HY_EMIT: begin
          acc_nxt = '0;
          has_res = 1'b1;
          res_unit = UNIT_W'(CHR_AMP);
        end
        HY_QUIET: has_res = 1'b0;
        default: begin
          has_res = 1'b1;
          res_status = STATUS_REJECT;
        end
      endcase
    end else if (!sx.valid) begin
      has_res = 1'b1;
      res_status = STATUS_REJECT;
    end else begin
      mode_nxt = row.next;
      if (row.split) begin
        has_res = 1'b1;
        res_unit = acc_r | UNIT_W'(split_val[SEXTET_W+UNIT_W-1:UNIT_W]);
        carry_nxt = split_val[UNIT_W-1:0];
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_r | carry_r | place_val[UNIT_W-1:0];
        carry_nxt = '0;
      end
    end
  end

  // A beat that yields nothing never waits on the output register.
  assign move = stage_vld_r && (!has_res || out_free);
  assign in_ch.ready = !stage_vld_r || move;
  assign take = in_ch.valid && in_ch.ready;

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (take) begin
      stage_vld_nxt = 1'b1;
    end else if (move) begin
      stage_vld_nxt = 1'b0;
    end
  end

  assign res.fire = move && has_res;
  assign res.status = res_status;
  assign res.code_unit = res_unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      mode_r <= MODE_ASCII;
      acc_r <= '0;
      carry_r <= '0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      if (move) begin
        mode_r <= mode_nxt;
        acc_r <= acc_nxt;
        carry_r <= carry_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.in_byte;
    end
  end

endmodule
`default_nettype wire

// ===== src/modified_utf7_decoder.sv =====
`default_nettype none
// Decodes modified UTF-7 (the IMAP mailbox name form) into UTF-16 code units,
// one byte per beat. Each accepted byte gives zero or one result beat: ASCII
// bytes pass through, '&' opens a base64 run, "&-" gives '&', and a bad byte or
// a '-' that cuts a unit short gives a reject beat (status 1, code unit zero).
// The block takes one byte every cycle while the output accepts results; a result
// passes through the input register and then the result register before it is
// presented. The result register lets the next byte in while a result waits.
module modified_utf7_decoder
  import mu7_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  mu7_in_if.sink     in_ch,
  mu7_out_if.source  out_ch
);

  mu7_res_t          res;
  logic              out_free;
  logic              out_vld_r, out_vld_nxt;
  logic              status_r;
  logic [UNIT_W-1:0] unit_r;

  assign out_free = !out_vld_r || out_ch.ready;

  mu7_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .res      (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res.fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fire) begin
      status_r <= res.status;
      unit_r <= res.code_unit;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.status = status_r;
  assign out_ch.code_unit = unit_r;

endmodule
`default_nettype wire

// ===== bench/modified_utf7_decoder_test.sv =====
`default_nettype none
module modified_utf7_decoder_test;
  import mu7_pkg::*;

  localparam int IDLE_PCT = 34;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 8;
  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+,";

  typedef struct {
    logic              status;
    logic [UNIT_W-1:0] code_unit;
  } decoded_unit_t;

  logic clk;
  logic rst_n;

  mu7_in_if  in_bus ();
  mu7_out_if out_bus ();

  modified_utf7_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  decoded_unit_t     pending_units [$];
  decoded_unit_t     oldest_unit;
  int                sextet_lut [256];
  int                errors = 0;
  int                bytes_sent;
  int                quiet_cycles = 0;
  bit                no_idle;

  // Decoder state as the predictor sees it.
  logic [MODE_W-1:0] model_mode;
  logic [UNIT_W-1:0] model_acc;
  logic [UNIT_W-1:0] model_carry;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void build_alphabet();
    for (int i = 0; i < 256; i++) sextet_lut[i] = -1;
    for (int k = 0; k < 64; k++) sextet_lut[ALPHABET[k]] = k;
  endfunction

  function automatic void push_unit(logic status, logic [UNIT_W-1:0] unit);
    decoded_unit_t u;
    u.status = status;
    u.code_unit = unit;
    pending_units.push_back(u);
  endfunction

  // Bit position of a sextet within the unit for each place in the group.
  function automatic int group_shift(logic [MODE_W-1:0] m);
    case (m)
      4'd1, MODE_AMP: return 10;
      4'd2, 4'd6:     return 4;
      4'd3, 4'd5:     return 2;
      4'd4:           return 8;
      4'd7:           return 6;
      default:        return 0;
    endcase
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b);
    int           sx;
    int           sh;
    logic [31:0]  wide;
    logic [MODE_W-1:0] m;
    m = model_mode;
    if (m == MODE_ASCII || m > MODE_AMP) begin
      if (b == CHR_AMP) begin
        model_acc = '0;
        model_carry = '0;
        model_mode = MODE_AMP;
      end else begin
        model_mode = MODE_ASCII;
        model_acc = '0;
        push_unit(STATUS_OK, {8'h00, b});
      end
      return;
    end
    if (b == CHR_HYPHEN) begin
      model_mode = MODE_ASCII;
      if (m == MODE_AMP) begin
        model_acc = '0;
        push_unit(STATUS_OK, {8'h00, CHR_AMP});
      end else if (!(m == 4'd1 || m == 4'd4 || m == 4'd7)) begin
        push_unit(STATUS_REJECT, '0);
      end
      return;
    end
    sx = sextet_lut[b];
    if (sx < 0) begin
      push_unit(STATUS_REJECT, '0);
      return;
    end
    sh = group_shift(m);
    model_mode = (m == 4'd8) ? 4'd1 : (m == MODE_AMP) ? 4'd2 : m + 4'd1;
    if (m == 4'd3 || m == 4'd6 || m == 4'd8) begin
      // Third and sixth sextets close a unit and leave bits over; the eighth closes one exactly.
      wide = 32'(sx) >> sh;
      push_unit(STATUS_OK, model_acc | wide[UNIT_W-1:0]);
      wide = 32'(sx) << (16 - sh);
      model_carry = wide[UNIT_W-1:0];
      model_acc = '0;
    end else begin
      wide = 32'(sx) << sh;
      model_acc = model_acc | model_carry | wide[UNIT_W-1:0];
      model_carry = '0;
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      in_bus.in_byte <= BYTE_W'($urandom);
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_units.size() != 0);
  endtask

  task automatic test_ascii_passthrough();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CHR_HYPHEN);
  endtask

  task automatic test_ampersand_escape();
    send_text("&-");
  endtask

  // A whole group of the top sextet value, closed at a unit boundary.
  task automatic test_full_groups();
    send_text("&,,,,,,,,-");
  endtask

  task automatic test_cut_unit();
    send_text("&AB-");
  endtask

  // Bytes above 'z' and '&' inside a run are rejected without losing state.
  task automatic test_invalid_bytes();
    send_text("&A{&B-");
  endtask

  task automatic test_random_stream(input int count);
    int target;
    int r;
    int n;
    logic [BYTE_W-1:0] b;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      r = $urandom_range(99);
      if (r < 30) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          do b = BYTE_W'($urandom); while (b == CHR_AMP);
          send_byte(b);
        end
      end else if (r < 90) begin
        send_byte(CHR_AMP);
        n = $urandom_range(0, 16);
        repeat (n) begin
          if ($urandom_range(99) < 5) send_byte(BYTE_W'($urandom));
          else send_byte(ALPHABET[$urandom_range(63)]);
        end
        if ($urandom_range(99) < 80) send_byte(CHR_HYPHEN);
      end else begin
        send_byte(BYTE_W'($urandom));
      end
    end
  endtask

  task automatic test_drain_pause();
    test_random_stream(40);
    wait_drained();
    test_random_stream(40);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_stream(150);
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_units.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got status %0d unit %h",
                 $time, out_bus.status, out_bus.code_unit);
      end else begin
        oldest_unit = pending_units.pop_front();
        if (out_bus.status !== oldest_unit.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d",
                   $time, oldest_unit.status, out_bus.status);
        end
        if (out_bus.code_unit !== oldest_unit.code_unit) begin
          errors++;
          $display("%0t: code_unit expected %h, got %h",
                   $time, oldest_unit.code_unit, out_bus.code_unit);
        end
      end
    end
    out_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    bytes_sent = 0;
    no_idle = 1'b0;
    model_mode = MODE_ASCII;
    model_acc = '0;
    model_carry = '0;
    build_alphabet();
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.in_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_ascii_passthrough();
    test_ampersand_escape();
    test_full_groups();
    test_cut_unit();
    test_invalid_bytes();
    test_random_stream(300);
    test_drain_pause();
    test_back_to_back();
    test_random_stream(220);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
